### sv/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared widths, limits, command/status structs and the digit symbol function
// for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_W        = 31;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int STEP_W         = $clog2(VALUE_W);
  localparam int MAX_DIGITS_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h57;

  typedef struct packed {
    logic load;
    logic err_load;
    logic div_step;
    logic store_wr;
    logic rd_issue;
    logic out_load;
  } rdc_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic step_last;
    logic q_zero;
    logic cnt_full;
    logic out_last;
  } rdc_status_t;

  function automatic logic [CHAR_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] base;
    base = (d < DIGIT_W'(10)) ? CHAR_ZERO : CHAR_LETTER;
    return base + CHAR_W'(d);
  endfunction

endpackage

### sv/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer for the radix digit converter: runs the bit-serial divisions,
// stores each remainder and walks the store back out; flags a bad radix.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rdc_pkg::rdc_status_t status,
  output rdc_pkg::rdc_cmd_t    cmd
);
  import rdc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_SHOW  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SHOW);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.radix_bad) begin
            cmd.err_load = 1'b1;
            state_next   = S_SHOW;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store_wr = 1'b1;
        if (status.q_zero || status.cnt_full) begin
          state_next = S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) begin
          state_next = status.out_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/rdc_dpath.sv
// ----------------------------------------------------------------------------
// rdc_dpath
// Datapath of the radix digit converter: restoring divider one quotient bit
// per cycle, digit store memory with registered read, and output register.
// ----------------------------------------------------------------------------
module rdc_dpath #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic [rdc_pkg::VALUE_W-1:0]   value,
  input  logic [rdc_pkg::RADIX_W-1:0]   radix,
  input  rdc_pkg::rdc_cmd_t             cmd,
  output rdc_pkg::rdc_status_t          status,
  output logic [rdc_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last,
  output logic                          error
);
  import rdc_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic [VALUE_W-1:0] quotient;
  logic [RADIX_W-1:0] radix_r;
  logic [DIGIT_W-1:0] rem;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   cnt;
  logic [DIGIT_W-1:0] rd_data;
  logic               rd_last;

  logic [DIGIT_W-1:0] store [MAX_DIGITS];

  logic [RADIX_W-1:0] trial;
  logic               ge;
  logic [RADIX_W-1:0] diff;
  logic [CNT_W-1:0]   cnt_dec;

  assign trial   = {rem, quotient[VALUE_W-1]};
  assign ge      = (trial >= radix_r);
  assign diff    = trial - radix_r;
  assign cnt_dec = cnt - CNT_W'(1);

  assign status.radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign status.step_last = (step == STEP_W'(VALUE_W - 1));
  assign status.q_zero    = (quotient == '0);
  assign status.cnt_full  = (cnt == CNT_W'(MAX_DIGITS - 1));
  assign status.out_last  = last;

  // divider and digit count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quotient <= value;
      radix_r  <= radix;
      rem      <= '0;
      step     <= '0;
      cnt      <= '0;
    end else if (cmd.div_step) begin
      quotient <= {quotient[VALUE_W-2:0], ge};
      rem      <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      step     <= step + STEP_W'(1);
    end else if (cmd.store_wr) begin
      cnt  <= cnt + CNT_W'(1);
      rem  <= '0;
      step <= '0;
    end else if (cmd.rd_issue) begin
      cnt <= cnt_dec;
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store[cnt[IDX_W-1:0]] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= store[cnt_dec[IDX_W-1:0]];
      rd_last <= (cnt_dec == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      digit_char <= '0;
      last       <= 1'b1;
      error      <= 1'b1;
    end else if (cmd.out_load) begin
      digit_char <= digit_symbol(rd_data);
      last       <= rd_last;
      error      <= 1'b0;
    end
  end

endmodule

### sv/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a 31-bit unsigned value to lower-case ASCII digits in radix 2..16,
// most significant digit first, with last marking the final digit.
// ----------------------------------------------------------------------------
// One request at a time. Each digit costs a full restoring division (31
// quotient bits, one per cycle, plus a store write); emission then takes
// each digit through the states READ (registered store read), LOAD and SHOW,
// plus any output stall. A radix outside 2..16
// answers with one result (error and last set, digit_char zero) in the cycle
// after the request. in_stall is high from acceptance until the last digit
// has been taken.
module radix_digit_converter_core #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rdc_pkg::VALUE_W-1:0] value,
  input  logic [rdc_pkg::RADIX_W-1:0] radix,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last,
  output logic                        error
);
  import rdc_pkg::*;

  rdc_cmd_t    cmd;
  rdc_status_t status;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .value      (value),
    .radix      (radix),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char),
    .last       (last),
    .error      (error)
  );

endmodule
